// ===== src/lwes_pkg.sv =====
// ----------------------------------------------------------------------------
// lwes_pkg
// shared types, codes and helpers of the weekly light event scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package lwes_pkg;

  // default sizes
  localparam int unsigned DEF_TABLE_ENTRIES = 64;
  localparam int unsigned DEF_LIGHT_COUNT   = 32;

  // item modes
  localparam logic [2:0] MODE_SCHED_ON  = 3'd0;
  localparam logic [2:0] MODE_SCHED_OFF = 3'd1;
  localparam logic [2:0] MODE_REMOVE    = 3'd2;
  localparam logic [2:0] MODE_RANDOMIZE = 3'd3;
  localparam logic [2:0] MODE_TICK      = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_ON     = 2'd1;
  localparam logic [1:0] KIND_OFF    = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_OOB  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  // day codes
  localparam logic [3:0] DAY_SUNDAY   = 4'd0;
  localparam logic [3:0] DAY_MONDAY   = 4'd1;
  localparam logic [3:0] DAY_FRIDAY   = 4'd5;
  localparam logic [3:0] DAY_SATURDAY = 4'd6;
  localparam logic [3:0] DAY_EVERYDAY = 4'd7;
  localparam logic [3:0] DAY_WEEKDAY  = 4'd8;
  localparam logic [3:0] DAY_WEEKEND  = 4'd9;

  // one table entry
  typedef struct packed {
    logic [7:0]        light;
    logic [3:0]        day;
    logic [10:0]       minute;
    logic              off_action;
    logic              randomized;
    logic signed [6:0] offset;
  } entry_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } lwes_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } lwes_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_end;
    logic out_free;
    logic has_final;
  } lwes_stat_t;

  function automatic logic day_matches(input logic [3:0] code, input logic [3:0] today);
    logic hit;
    hit = 1'b0;
    if (code == DAY_EVERYDAY) hit = 1'b1;
    if (code == today) hit = 1'b1;
    if (code == DAY_WEEKEND && (today == DAY_SUNDAY || today == DAY_SATURDAY)) hit = 1'b1;
    if (code == DAY_WEEKDAY && today >= DAY_MONDAY && today <= DAY_FRIDAY) hit = 1'b1;
    return hit;
  endfunction

endpackage

`default_nettype wire

// ===== src/lwes_in_if.sv =====
// ----------------------------------------------------------------------------
// lwes_in_if
// input item channel: valid, ready and item fields
// ----------------------------------------------------------------------------
`default_nettype none

interface lwes_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic [7:0]        light_id;
  logic [3:0]        day_code;
  logic [10:0]       minute_of_day;
  logic signed [6:0] random_offset;

  modport source (
    output valid, mode, light_id, day_code, minute_of_day, random_offset,
    input  ready
  );
  modport sink (
    input  valid, mode, light_id, day_code, minute_of_day, random_offset,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/lwes_out_if.sv =====
// ----------------------------------------------------------------------------
// lwes_out_if
// result channel: valid, ready and result fields
// ----------------------------------------------------------------------------
`default_nettype none

interface lwes_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] status;
  logic [7:0] target_light;
  logic       last;

  modport source (
    output valid, kind, status, target_light, last,
    input  ready
  );
  modport sink (
    input  valid, kind, status, target_light, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/weekly_light_event_scheduler.sv =====
// ----------------------------------------------------------------------------
// weekly_light_event_scheduler
// weekly table of light on/off events with schedule, remove, randomize, tick
// ----------------------------------------------------------------------------
//
//   channel  dir  transfer carries
//   -------  ---  ---------------------------------------------------------
//   in_i     in   mode, light_id, day_code, minute_of_day, random_offset
//   out_o    out  kind, status, target_light, last
//
// every item sweeps the whole table, one entry per cycle unless the result
// port stalls it (capture, sweep with a registered table read, end-of-sweep
// step, closing result), set by the single read port of the table memory
// a stalled result port holds the sweep only when a second fired command
// meets a full output register; the output register lets a new item be
// taken while the last result still waits
// reset empties the table at once (valid flags); entry contents need none
// ----------------------------------------------------------------------------
`default_nettype none

module weekly_light_event_scheduler #(
  parameter int unsigned TABLE_ENTRIES = lwes_pkg::DEF_TABLE_ENTRIES,
  parameter int unsigned LIGHT_COUNT   = lwes_pkg::DEF_LIGHT_COUNT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lwes_in_if.sink   in_i,
  lwes_out_if.source out_o
);
  import lwes_pkg::*;

  lwes_cmd_t  cmd;   // sequencer commands
  lwes_stat_t stat;  // datapath status back to the sequencer

  // sequencer: idle -> sweep -> closing result
  lwes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table, sweep pipeline and result register
  lwes_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .LIGHT_COUNT   (LIGHT_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mode_i          (in_i.mode),
    .light_id_i      (in_i.light_id),
    .day_code_i      (in_i.day_code),
    .minute_of_day_i (in_i.minute_of_day),
    .random_offset_i (in_i.random_offset),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .kind_o          (out_o.kind),
    .status_o        (out_o.status),
    .target_light_o  (out_o.target_light),
    .last_o          (out_o.last)
  );

endmodule

`default_nettype wire

// ===== src/lwes_ctrl.sv =====
// ----------------------------------------------------------------------------
// lwes_ctrl
// sequencer: accept an item, run the table scan, deliver the closing result
// ----------------------------------------------------------------------------
`default_nettype none

module lwes_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire lwes_pkg::lwes_stat_t stat_i,
  output lwes_pkg::lwes_cmd_t      cmd_o
);
  import lwes_pkg::*;

  lwes_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_end) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!stat_i.has_final || stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/lwes_dp.sv =====
// ----------------------------------------------------------------------------
// lwes_dp
// event table, scan pipeline, held command and output register
// ----------------------------------------------------------------------------
`default_nettype none

module lwes_dp #(
  parameter int unsigned TABLE_ENTRIES = lwes_pkg::DEF_TABLE_ENTRIES,
  parameter int unsigned LIGHT_COUNT   = lwes_pkg::DEF_LIGHT_COUNT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire lwes_pkg::lwes_cmd_t  cmd_i,
  output lwes_pkg::lwes_stat_t      stat_o,
  input  wire logic [2:0]           mode_i,
  input  wire logic [7:0]           light_id_i,
  input  wire logic [3:0]           day_code_i,
  input  wire logic [10:0]          minute_of_day_i,
  input  wire logic signed [6:0]    random_offset_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [1:0]                kind_o,
  output logic [1:0]                status_o,
  output logic [7:0]                target_light_o,
  output logic                      last_o
);
  import lwes_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_ENTRIES);

  // captured item
  logic [2:0]        mode_q;
  logic [7:0]        light_q;
  logic [3:0]        day_q;
  logic [10:0]       minute_q;
  logic signed [6:0] offset_q;

  // scan pipeline
  logic [CNT_W-1:0]         idx_q;
  logic                     ev_vld_q;
  logic [IDX_W-1:0]         ev_idx_q;
  entry_t                   rd_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic                     found_q;
  entry_t                   mem_q [TABLE_ENTRIES];

  // held command, sent once the next one (or the scan end) is known
  logic       pend_vld_q;
  logic       pend_off_q;
  logic [7:0] pend_light_q;

  // output register
  logic       out_vld_q;
  logic [1:0] out_kind_q;
  logic [1:0] out_status_q;
  logic [7:0] out_light_q;
  logic       out_last_q;

  logic        is_sched, is_tick, oob, idx_end, ev_v, key_hit, fire;
  logic        out_free, stall, adv, eval, rd_en;
  logic        mem_we, set_valid, clr_valid, push_pend, push_final;
  entry_t      mem_wdata;
  logic [12:0] due;

  assign is_sched = (mode_q == MODE_SCHED_ON) || (mode_q == MODE_SCHED_OFF);
  assign is_tick  = (mode_q == MODE_TICK);
  assign oob      = ({1'b0, light_q} >= 9'(LIGHT_COUNT));
  assign idx_end  = (idx_q == CNT_END);
  assign ev_v     = valid_q[ev_idx_q];
  assign key_hit  = ev_v && (rd_q.light == light_q) && (rd_q.day == day_q)
                    && (rd_q.minute == minute_q);
  // minute plus signed offset, compared without wrap
  assign due      = {2'b00, rd_q.minute} + {{6{rd_q.offset[6]}}, rd_q.offset};
  assign fire     = ev_vld_q && is_tick && ev_v && day_matches(rd_q.day, day_q)
                    && (due == {2'b00, minute_q});

  assign out_free = !out_vld_q || out_ready_i;
  assign stall    = fire && pend_vld_q && !out_free;
  assign adv      = cmd_i.scan && !stall;
  assign eval     = adv && ev_vld_q;
  assign rd_en    = adv && !idx_end;

  assign push_pend  = eval && fire && pend_vld_q;
  assign push_final = cmd_i.finish && stat_o.has_final && out_free;

  // table updates for the entry in the evaluate stage
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_q;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    if (eval) begin
      case (mode_q)
        MODE_SCHED_ON, MODE_SCHED_OFF: begin
          if (!oob && !found_q && !ev_v) begin
            set_valid            = 1'b1;
            mem_we               = 1'b1;
            mem_wdata.light      = light_q;
            mem_wdata.day        = day_q;
            mem_wdata.minute     = minute_q;
            mem_wdata.off_action = mode_q[0];
            mem_wdata.randomized = 1'b0;
            mem_wdata.offset     = '0;
          end
        end
        MODE_REMOVE: begin
          clr_valid = key_hit;
        end
        MODE_RANDOMIZE: begin
          if (key_hit) begin
            mem_we               = 1'b1;
            mem_wdata.randomized = 1'b1;
            mem_wdata.offset     = offset_q;
          end
        end
        MODE_TICK: begin
          if (fire && rd_q.randomized) begin
            mem_we           = 1'b1;
            mem_wdata.offset = offset_q;
          end
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[ev_idx_q] <= mem_wdata;
    if (rd_en)  rd_q <= mem_q[idx_q[IDX_W-1:0]];
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      light_q  <= light_id_i;
      day_q    <= day_code_i;
      minute_q <= minute_of_day_i;
      offset_q <= random_offset_i;
    end
    if (eval && fire) begin
      pend_off_q   <= rd_q.off_action;
      pend_light_q <= rd_q.light;
    end
  end

  // scan control and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      ev_vld_q   <= 1'b0;
      ev_idx_q   <= '0;
      valid_q    <= '0;
      found_q    <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        idx_q    <= '0;
        ev_vld_q <= 1'b0;
        found_q  <= 1'b0;
      end else if (adv) begin
        ev_vld_q <= !idx_end;
        if (!idx_end) begin
          ev_idx_q <= idx_q[IDX_W-1:0];
          idx_q    <= idx_q + 1'b1;
        end
      end
      if (set_valid) begin
        valid_q[ev_idx_q] <= 1'b1;
        found_q           <= 1'b1;
      end
      if (clr_valid) valid_q[ev_idx_q] <= 1'b0;
      if (eval && fire) begin
        pend_vld_q <= 1'b1;
      end else if (push_final) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (push_pend || push_final) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_pend) begin
      out_kind_q   <= pend_off_q ? KIND_OFF : KIND_ON;
      out_status_q <= STAT_OK;
      out_light_q  <= pend_light_q;
      out_last_q   <= 1'b0;
    end else if (push_final) begin
      out_last_q <= 1'b1;
      if (is_sched) begin
        out_kind_q   <= KIND_STATUS;
        out_light_q  <= '0;
        out_status_q <= oob ? STAT_OOB : (found_q ? STAT_OK : STAT_FULL);
      end else begin
        out_kind_q   <= pend_off_q ? KIND_OFF : KIND_ON;
        out_light_q  <= pend_light_q;
        out_status_q <= STAT_OK;
      end
    end
  end

  assign stat_o.scan_end  = idx_end && !ev_vld_q;
  assign stat_o.out_free  = out_free;
  assign stat_o.has_final = is_sched || pend_vld_q;

  assign out_valid_o    = out_vld_q;
  assign kind_o         = out_kind_q;
  assign status_o       = out_status_q;
  assign target_light_o = out_light_q;
  assign last_o         = out_last_q;

endmodule

`default_nettype wire
